// ----- rtl/tmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and constants of the temperature trimmed-mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

    // Field widths.
    localparam int MV_W     = 12;
    localparam int TIME_W   = 32;
    localparam int CFG16_W  = 16;
    localparam int TEMP_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd3;

    // Register values after reset.
    localparam logic [MV_W-1:0]    RST_MAX_MV   = 12'd1500;
    localparam logic [CFG16_W-1:0] RST_INTERVAL = 16'd10;
    localparam logic [CFG16_W-1:0] RST_TIMEOUT  = 16'd2000;
    localparam logic [CFG16_W-1:0] RST_ALPHA    = 16'd11796;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_REM,
        ST_FIX,
        ST_MUL1,
        ST_MUL2,
        ST_FINISH
    } t_state;

    // Control of the sorting chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_chain_ctl;

endpackage

// ----- rtl/tmf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_cell
// One cell of the sorting chain: holds one reading, takes part in a sorted
// insert and shifts toward the head of the chain during readout.
// ----------------------------------------------------------------------------
module tmf_cell (
    input  logic                    i_clk,
    input  tmf_pkg::t_chain_ctl     i_ctl,
    input  logic [tmf_pkg::MV_W-1:0] i_value,
    input  logic                    i_occ,
    input  logic                    i_prev_gt,
    input  logic [tmf_pkg::MV_W-1:0] i_prev_value,
    input  logic [tmf_pkg::MV_W-1:0] i_next_value,
    output logic [tmf_pkg::MV_W-1:0] o_value,
    output logic                    o_gt
);
    import tmf_pkg::*;

    logic [MV_W-1:0] r_value;
    logic [MV_W-1:0] n_value;

    // This cell holds a reading larger than the incoming one.
    assign o_gt    = i_occ && (r_value > i_value);
    assign o_value = r_value;

    // Sorted insert: larger entries move one place toward the tail, and the
    // new reading lands in the first place that is empty or larger.
    always_comb begin
        n_value = r_value;
        if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
            end else if (!i_occ || (r_value > i_value)) begin
                n_value = i_value;
            end
        end else if (i_ctl.shift) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/tmf_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_chain
// Row of sorting cells. Readings are inserted in sorted position; during readout the
// row shifts toward cell 0, which presents the smallest remaining entry.
// ----------------------------------------------------------------------------
module tmf_chain #(
    parameter int WINDOW_SIZE = 16,
    parameter int CNT_W       = 4
) (
    input  logic                     i_clk,
    input  tmf_pkg::t_chain_ctl      i_ctl,
    input  logic [tmf_pkg::MV_W-1:0] i_value,
    input  logic [CNT_W-1:0]         i_count,
    output logic [tmf_pkg::MV_W-1:0] o_head
);
    import tmf_pkg::*;

    logic [MV_W-1:0] w_value [WINDOW_SIZE];
    logic            w_gt    [WINDOW_SIZE];

    genvar g;
    generate
        for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
            logic            w_occ;
            logic            w_prev_gt;
            logic [MV_W-1:0] w_prev_value;
            logic [MV_W-1:0] w_next_value;

            // Cells below the fill count hold readings of this window.
            assign w_occ = (CNT_W'(g) < i_count);

            if (g == 0) begin : g_first
                assign w_prev_gt    = 1'b0;
                assign w_prev_value = '0;
            end else begin : g_mid
                assign w_prev_gt    = w_gt[g-1];
                assign w_prev_value = w_value[g-1];
            end

            if (g == WINDOW_SIZE - 1) begin : g_last
                assign w_next_value = '0;
            end else begin : g_body
                assign w_next_value = w_value[g+1];
            end

            tmf_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (i_ctl),
                .i_value      (i_value),
                .i_occ        (w_occ),
                .i_prev_gt    (w_prev_gt),
                .i_prev_value (w_prev_value),
                .i_next_value (w_next_value),
                .o_value      (w_value[g]),
                .o_gt         (w_gt[g])
            );
        end
    endgenerate

    assign o_head = w_value[0];

endmodule

// ----- rtl/temperature_trimmed_mean_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_trimmed_mean_filter
// Gated sampling into a sorting chain, trimmed mean, conversion to Q8
// degrees and exponential smoothing.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries a millisecond timestamp
//   and a reading in millivolts. Output channel (o_out_valid / i_out_ready)
//   returns exactly one result per input transfer, in order.
// - Configuration is a plain write port (i_cfg_wr_en, i_cfg_index,
//   i_cfg_wdata); write it only while no item is in flight.
// - Readings enter a row of WINDOW_SIZE sorting cells as they arrive, so an
//   ordinary item's result is registered at the edge of its input transfer,
//   and a new transfer can follow as soon as the output register allows.
// - The item that fills the window takes longer: the row shifts out through
//   one adder, the division by the constant divisor is a reciprocal
//   multiply, a remainder and a correction step, and the filter update uses
//   two multiply steps.
// - The output register holds a result while the receiver stalls; an idle
//   sequencer takes a new transfer if that register is free or drains this cycle.
// - Synchronous reset loads the register defaults, clears the time marks,
//   the fill count and the filter flags, and empties the output register.
// ----------------------------------------------------------------------------
module temperature_trimmed_mean_filter #(
    parameter int WINDOW_SIZE   = 16,
    parameter int TRIM_PER_SIDE = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_wr_en,
    input  logic [tmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmf_pkg::CFG16_W-1:0]   i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tmf_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [tmf_pkg::MV_W-1:0]      i_millivolts,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_sample_taken,
    output logic                          o_window_done,
    output logic                          o_temperature_valid,
    output logic [tmf_pkg::TEMP_W-1:0]    o_temperature_q8
);
    import tmf_pkg::*;

    // Window geometry and divider sizing.
    localparam int TRIM_EFF  = (2 * TRIM_PER_SIDE >= WINDOW_SIZE) ? 0 : TRIM_PER_SIDE;
    localparam int KEPT      = WINDOW_SIZE - 2 * TRIM_EFF;
    localparam int DEN       = 20 * KEPT;
    localparam int ROUND_ADD = 10 * KEPT;
    localparam int CNT_W     = $clog2(WINDOW_SIZE);
    localparam int SW        = $clog2(WINDOW_SIZE * 4095 + 1);
    localparam int NW        = SW + 10;
    localparam int RECIP     = (1 << NW) / DEN;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int QPW       = NW + RW;
    localparam int PROD_W    = 33;

    localparam logic [NW-1:0] DEN_N   = NW'(DEN);
    localparam logic [RW-1:0] RECIP_R = RW'(RECIP);

    // Configuration registers.
    logic [MV_W-1:0]    r_max_mv;
    logic [CFG16_W-1:0] r_interval;
    logic [CFG16_W-1:0] r_timeout;
    logic [CFG16_W-1:0] r_alpha;

    // Control state.
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_last_sample;
    logic [TIME_W-1:0]  r_last_valid;
    logic               r_loaded;
    logic               r_valid_flag;
    logic [CNT_W-1:0]   r_k;

    // Datapath registers.
    logic [TEMP_W-1:0]  r_filt;
    logic [TIME_W-1:0]  r_now;
    logic [SW-1:0]      r_sum;
    logic [NW-1:0]      r_div;
    logic [QPW-1:0]     r_qprod;
    logic [RW-1:0]      r_quot;
    logic [NW-1:0]      r_rem;
    logic [TEMP_W-1:0]  r_meas;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_acc;

    // Output register.
    logic               r_out_valid;
    logic               r_out_taken;
    logic               r_out_done;
    logic               r_out_tvalid;
    logic [TEMP_W-1:0]  r_out_temp;

    // Combinational signals.
    t_chain_ctl         w_ctl;
    logic               w_accept;
    logic               w_slot_free;
    logic [MV_W-1:0]    w_head;
    logic               w_taken;
    logic               w_store;
    logic               w_complete;
    logic               w_timeout;
    logic               w_sum_last;
    logic               w_in_trim;
    logic [SW-1:0]      n_sum;
    logic [NW-1:0]      w_numer;
    logic [RW-1:0]      w_quot0;
    logic [NW-1:0]      w_rem;
    logic               w_round_up;
    logic [RW-1:0]      w_quot;
    logic [16:0]        w_one_minus;
    logic [TEMP_W-1:0]  w_filt_new;
    logic               w_tmo_zero;

    // Sorting chain.
    tmf_chain #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .CNT_W       (CNT_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (i_millivolts),
        .i_count (r_count),
        .o_head  (w_head)
    );

    // Sample gate, validity limit and timeout for the arriving item.
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_taken     = (i_now_ms - r_last_sample) >= {16'd0, r_interval};
    assign w_store     = w_taken && (i_millivolts <= r_max_mv);
    assign w_complete  = w_store && (r_count == CNT_W'(WINDOW_SIZE - 1));
    assign w_timeout   = w_taken && ((i_now_ms - r_last_valid) >= {16'd0, r_timeout});
    assign w_tmo_zero  = (r_timeout == '0);

    // Trimmed sum over the entries leaving the head of the chain.
    assign w_sum_last = (r_k == CNT_W'(WINDOW_SIZE - 1));
    assign w_in_trim  = (32'(r_k) >= TRIM_EFF) && (32'(r_k) < WINDOW_SIZE - TRIM_EFF);
    assign n_sum      = w_in_trim ? (r_sum + SW'(w_head)) : r_sum;
    assign w_numer    = (NW'(n_sum) << 9) + NW'(ROUND_ADD);

    // Division by the constant divisor: the reciprocal product gives the
    // quotient or one less, and the remainder decides the final step.
    assign w_quot0    = r_qprod[QPW-1:NW];
    assign w_rem      = r_div - (NW'(w_quot0) * DEN_N);
    assign w_round_up = (r_rem >= DEN_N);
    assign w_quot     = r_quot + RW'(w_round_up);

    // Filter weights and the updated filter value.
    assign w_one_minus = 17'h10000 - {1'b0, r_alpha};
    assign w_filt_new  = r_loaded ? r_acc[31:16] : r_meas;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_complete) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_sum_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_state = ST_REM;
            end
            ST_REM: begin
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready   = 1'b0;
        w_ctl.insert = 1'b0;
        w_ctl.shift  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = w_slot_free;
                w_ctl.insert = i_in_valid && w_slot_free && w_store;
            end
            ST_SUM: begin
                w_ctl.shift = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mv   <= RST_MAX_MV;
            r_interval <= RST_INTERVAL;
            r_timeout  <= RST_TIMEOUT;
            r_alpha    <= RST_ALPHA;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_MV:   r_max_mv   <= i_cfg_wdata[MV_W-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_wdata;
                CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                CFG_ALPHA:    r_alpha    <= i_cfg_wdata;
                default:      r_alpha    <= r_alpha;
            endcase
        end
    end

    // Control state: gate marks, fill count, filter flags, counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_last_sample <= '0;
            r_last_valid  <= '0;
            r_loaded      <= 1'b0;
            r_valid_flag  <= 1'b0;
            r_k           <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (w_accept && w_taken) begin
                        r_last_sample <= i_now_ms;
                        if (w_complete) begin
                            r_count <= '0;
                        end else if (w_timeout) begin
                            r_count      <= '0;
                            r_loaded     <= 1'b0;
                            r_valid_flag <= 1'b0;
                        end else if (w_store) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                ST_SUM: begin
                    r_k <= r_k + CNT_W'(1);
                end
                ST_FINISH: begin
                    if (w_slot_free) begin
                        r_last_valid <= r_now;
                        // A zero timeout expires even on the completing item.
                        r_loaded     <= !w_tmo_zero;
                        r_valid_flag <= !w_tmo_zero;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // Window datapath: trimmed sum, division and filter products.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_now <= i_now_ms;
                r_sum <= '0;
            end
            ST_SUM: begin
                r_sum <= n_sum;
                if (w_sum_last) begin
                    r_div <= w_numer;
                end
            end
            ST_DIV: begin
                r_qprod <= QPW'(r_div) * QPW'(RECIP_R);
            end
            ST_REM: begin
                r_quot <= w_quot0;
                r_rem  <= w_rem;
            end
            ST_FIX: begin
                r_meas <= (32'(w_quot) > 32'd65535) ? 16'hFFFF : TEMP_W'(w_quot);
            end
            ST_MUL1: begin
                r_prod <= PROD_W'(r_filt) * PROD_W'(w_one_minus);
            end
            ST_MUL2: begin
                r_acc <= r_prod + (PROD_W'(r_meas) * PROD_W'(r_alpha)) + PROD_W'(32768);
            end
            ST_FINISH: begin
                if (w_slot_free) begin
                    r_filt <= w_filt_new;
                end
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_IDLE) && w_accept && !w_complete) begin
            r_out_valid <= 1'b1;
        end else if ((r_state == ST_FINISH) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && w_accept && !w_complete) begin
            r_out_taken  <= w_taken;
            r_out_done   <= 1'b0;
            r_out_tvalid <= r_valid_flag && !w_timeout;
            r_out_temp   <= (r_valid_flag && !w_timeout) ? r_filt : '0;
        end else if ((r_state == ST_FINISH) && w_slot_free) begin
            r_out_taken  <= 1'b1;
            r_out_done   <= 1'b1;
            r_out_tvalid <= !w_tmo_zero;
            r_out_temp   <= w_tmo_zero ? '0 : w_filt_new;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_sample_taken      = r_out_taken;
    assign o_window_done       = r_out_done;
    assign o_temperature_valid = r_out_tvalid;
    assign o_temperature_q8    = r_out_temp;

endmodule
